[design/dtcps_pkg.sv]
`default_nettype none
package dtcps_pkg;

	// field and register widths
	localparam int FREQ_WIDTH   = 11;
	localparam int KEY_WIDTH    = 8;
	localparam int IDX_WIDTH    = 22;
	localparam int TOL_WIDTH    = 24;
	localparam int CNT_WIDTH    = 11;
	localparam int STATUS_WIDTH = 2;

	// stream payload widths, padded to whole bytes
	localparam int IN_DATA_WIDTH  = ((KEY_WIDTH + IDX_WIDTH + 7) / 8) * 8;
	localparam int OUT_DATA_WIDTH = ((STATUS_WIDTH + 2 * CNT_WIDTH + 7) / 8) * 8;

	// product, magnitude and signed error widths
	localparam int PROD_WIDTH    = 2 * FREQ_WIDTH;
	localparam int MAG_WIDTH     = PROD_WIDTH + 1;
	localparam int ERR_WIDTH     = PROD_WIDTH + 2;
	localparam int DIV_CNT_WIDTH = $clog2(PROD_WIDTH);

	localparam logic [TOL_WIDTH-1:0] TOL_RESET = TOL_WIDTH'(1280000);

	// result status codes
	typedef enum logic [STATUS_WIDTH-1:0] {
		STATUS_FOUND       = 2'd0,
		STATUS_UNKNOWN_KEY = 2'd1,
		STATUS_NO_PAIR     = 2'd2
	} status_t;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_LOCATE,
		ST_MUL,
		ST_SUB,
		ST_SEARCH,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic                  hit;
		logic [FREQ_WIDTH-1:0] lo;
		logic [FREQ_WIDTH-1:0] hi;
	} key_info_t;

	// controller to datapath commands
	typedef struct packed {
		logic    load;
		logic    prod;
		logic    div_step;
		logic    loc_step;
		logic    mul;
		logic    sub;
		logic    srch_step;
		logic    res_load;
		status_t res_status;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic key_hit;
		logic div_last;
		logic loc_more;
		logic loc_past;
		logic pair_hit;
		logic search_end;
		logic out_free;
	} stat_t;

	// keypad character to low and high tone
	function automatic key_info_t key_lookup(input logic [KEY_WIDTH-1:0] ch);
		key_info_t k;
		k = '0;
		k.hit = 1'b1;
		unique case (ch)
			8'h31: begin k.lo = FREQ_WIDTH'(697); k.hi = FREQ_WIDTH'(1209); end // '1'
			8'h30: begin k.lo = FREQ_WIDTH'(941); k.hi = FREQ_WIDTH'(1336); end // '0'
			8'h32: begin k.lo = FREQ_WIDTH'(697); k.hi = FREQ_WIDTH'(1336); end // '2'
			8'h33: begin k.lo = FREQ_WIDTH'(697); k.hi = FREQ_WIDTH'(1477); end // '3'
			8'h34: begin k.lo = FREQ_WIDTH'(770); k.hi = FREQ_WIDTH'(1209); end // '4'
			8'h35: begin k.lo = FREQ_WIDTH'(770); k.hi = FREQ_WIDTH'(1336); end // '5'
			8'h36: begin k.lo = FREQ_WIDTH'(770); k.hi = FREQ_WIDTH'(1477); end // '6'
			8'h37: begin k.lo = FREQ_WIDTH'(852); k.hi = FREQ_WIDTH'(1209); end // '7'
			8'h38: begin k.lo = FREQ_WIDTH'(852); k.hi = FREQ_WIDTH'(1336); end // '8'
			8'h39: begin k.lo = FREQ_WIDTH'(852); k.hi = FREQ_WIDTH'(1477); end // '9'
			8'h41: begin k.lo = FREQ_WIDTH'(697); k.hi = FREQ_WIDTH'(1633); end // 'A'
			8'h42: begin k.lo = FREQ_WIDTH'(770); k.hi = FREQ_WIDTH'(1633); end // 'B'
			8'h43: begin k.lo = FREQ_WIDTH'(852); k.hi = FREQ_WIDTH'(1633); end // 'C'
			8'h44: begin k.lo = FREQ_WIDTH'(941); k.hi = FREQ_WIDTH'(1633); end // 'D'
			8'h2A: begin k.lo = FREQ_WIDTH'(941); k.hi = FREQ_WIDTH'(1209); end // '*'
			8'h23: begin k.lo = FREQ_WIDTH'(941); k.hi = FREQ_WIDTH'(1477); end // '#'
			default: k.hit = 1'b0;
		endcase
		return k;
	endfunction

endpackage
`default_nettype wire

[design/dtcps_datapath.sv]
`default_nettype none
module dtcps_datapath (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [dtcps_pkg::TOL_WIDTH-1:0]      cfg_data,
	input  wire logic [dtcps_pkg::IN_DATA_WIDTH-1:0]  s_tdata,
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	output logic [dtcps_pkg::OUT_DATA_WIDTH-1:0]      m_tdata,
	input  wire dtcps_pkg::cmd_t                      cmd,
	output dtcps_pkg::stat_t                          stat
);
	import dtcps_pkg::*;

	logic [TOL_WIDTH-1:0]     tol_q;
	logic                     hit_q;
	logic [FREQ_WIDTH-1:0]    fl_q;
	logic [FREQ_WIDTH-1:0]    fh_q;
	logic [IDX_WIDTH-1:0]     rem_q;
	logic [FREQ_WIDTH-1:0]    d_q;
	logic [FREQ_WIDTH-1:0]    n_q;
	logic [PROD_WIDTH-1:0]    dvd_q;
	logic [PROD_WIDTH-1:0]    quo_q;
	logic [TOL_WIDTH-1:0]     rdiv_q;
	logic [DIV_CNT_WIDTH-1:0] div_cnt_q;
	logic [MAG_WIDTH-1:0]     a_q;
	logic [MAG_WIDTH-1:0]     b_q;
	logic [MAG_WIDTH-1:0]     ahead_q;
	logic signed [ERR_WIDTH-1:0] e_q;
	logic                     out_valid_q;
	status_t                  out_status_q;
	logic [CNT_WIDTH-1:0]     out_n_q;
	logic [CNT_WIDTH-1:0]     out_m_q;

	key_info_t                key;
	logic [TOL_WIDTH:0]       trial;
	logic                     trial_ge;
	logic [IDX_WIDTH-1:0]     d_plus_ext;
	logic [FREQ_WIDTH-1:0]    n_start;
	logic [FREQ_WIDTH:0]      n_plus;
	logic [FREQ_WIDTH:0]      p_plus;
	logic [FREQ_WIDTH:0]      d_plus;
	logic [MAG_WIDTH-1:0]     a_prod;
	logic [MAG_WIDTH-1:0]     b_prod;
	logic [MAG_WIDTH-1:0]     ahead_prod;
	logic [MAG_WIDTH-1:0]     fh_ext;
	logic [MAG_WIDTH-1:0]     fl_ext;
	logic [MAG_WIDTH-1:0]     ahead_next;
	logic signed [ERR_WIDTH-1:0] neg_e;
	logic [MAG_WIDTH-1:0]     abs_e;
	logic [MAG_WIDTH-1:0]     thr;

	assign cfg_ready = 1'b1;

	// decode the key of the incoming transaction
	assign key = key_lookup(s_tdata[KEY_WIDTH-1:0]);

	// restoring divider step: one quotient bit per cycle
	assign trial    = {rdiv_q, dvd_q[PROD_WIDTH-1]};
	assign trial_ge = (trial >= {1'b0, tol_q});

	// match threshold: floor(fl*fh / tol), unbounded for zero tolerance
	assign thr = (tol_q == '0) ? '1 : MAG_WIDTH'(quo_q);

	// locate and setup arithmetic
	assign d_plus_ext = IDX_WIDTH'(d_q) + IDX_WIDTH'(1);
	assign n_start    = d_q - rem_q[FREQ_WIDTH-1:0];
	assign n_plus     = {1'b0, n_start} + (FREQ_WIDTH+1)'(1);
	assign p_plus     = {1'b0, rem_q[FREQ_WIDTH-1:0]} + (FREQ_WIDTH+1)'(1);
	assign d_plus     = {1'b0, d_q} + (FREQ_WIDTH+1)'(1);
	assign a_prod     = n_plus * fh_q;
	assign b_prod     = p_plus * fl_q;
	assign ahead_prod = d_plus * fh_q;

	// search step arithmetic
	assign fh_ext     = MAG_WIDTH'(fh_q);
	assign fl_ext     = MAG_WIDTH'(fl_q);
	assign ahead_next = ahead_q + fh_ext;
	assign neg_e      = -e_q;
	assign abs_e      = e_q[ERR_WIDTH-1] ? neg_e[MAG_WIDTH-1:0] : e_q[MAG_WIDTH-1:0];

	// status toward the controller
	always_comb begin
		stat.key_hit    = hit_q;
		stat.div_last   = (div_cnt_q == DIV_CNT_WIDTH'(PROD_WIDTH - 1));
		stat.loc_more   = (d_q < fh_q) && (rem_q >= d_plus_ext);
		stat.loc_past   = (d_q == fh_q);
		stat.pair_hit   = (n_q < fl_q) && (abs_e <= thr);
		stat.search_end = (n_q == '0) && (d_q == fh_q - FREQ_WIDTH'(1));
		stat.out_free   = !out_valid_q || m_tready;
	end

	// tolerance register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
		end else if (cfg_valid) begin
			tol_q <= cfg_data;
		end
	end

	// item registers, divider, locate and search counters
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			hit_q <= key.hit;
			fl_q  <= key.lo;
			fh_q  <= key.hi;
			rem_q <= s_tdata[KEY_WIDTH +: IDX_WIDTH];
			d_q   <= '0;
		end
		if (cmd.prod) begin
			dvd_q     <= fl_q * fh_q;
			quo_q     <= '0;
			rdiv_q    <= '0;
			div_cnt_q <= '0;
		end
		if (cmd.div_step) begin
			dvd_q     <= {dvd_q[PROD_WIDTH-2:0], 1'b0};
			quo_q     <= {quo_q[PROD_WIDTH-2:0], trial_ge};
			rdiv_q    <= trial_ge ? TOL_WIDTH'(trial - {1'b0, tol_q}) : trial[TOL_WIDTH-1:0];
			div_cnt_q <= div_cnt_q + DIV_CNT_WIDTH'(1);
		end
		if (cmd.loc_step) begin
			rem_q <= rem_q - d_plus_ext;
			d_q   <= d_q + FREQ_WIDTH'(1);
		end
		if (cmd.mul) begin
			n_q     <= n_start;
			a_q     <= a_prod;
			b_q     <= b_prod;
			ahead_q <= ahead_prod;
		end
		if (cmd.sub) begin
			e_q <= $signed({1'b0, a_q}) - $signed({1'b0, b_q});
		end
		if (cmd.srch_step) begin
			if (n_q == '0) begin
				// move to the top of the next diagonal
				d_q     <= d_q + FREQ_WIDTH'(1);
				n_q     <= d_q + FREQ_WIDTH'(1);
				ahead_q <= ahead_next;
				e_q     <= $signed({1'b0, ahead_next}) - $signed({1'b0, fl_ext});
			end else begin
				n_q <= n_q - FREQ_WIDTH'(1);
				e_q <= e_q - $signed({1'b0, fh_ext + fl_ext});
			end
		end
	end

	// output register: hold the result until the transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			out_status_q <= cmd.res_status;
			if (cmd.res_status == STATUS_FOUND) begin
				out_n_q <= CNT_WIDTH'(n_q);
				out_m_q <= CNT_WIDTH'(d_q - n_q);
			end else begin
				out_n_q <= '0;
				out_m_q <= '0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_DATA_WIDTH'({out_m_q, out_n_q, out_status_q});

endmodule
`default_nettype wire

[design/dtcps_ctrl.sv]
`default_nettype none
module dtcps_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	output dtcps_pkg::cmd_t        cmd,
	input  wire dtcps_pkg::stat_t  stat
);
	import dtcps_pkg::*;

	state_t  state_q;
	state_t  state_nxt;
	status_t status_q;
	status_t status_nxt;

	// state and pending status registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			status_q <= STATUS_FOUND;
		end else begin
			state_q  <= state_nxt;
			status_q <= status_nxt;
		end
	end

	// next state and commands
	always_comb begin
		state_nxt      = state_q;
		status_nxt     = status_q;
		s_tready       = 1'b0;
		cmd            = '0;
		cmd.res_status = status_q;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load  = 1'b1;
					state_nxt = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (!stat.key_hit) begin
					status_nxt = STATUS_UNKNOWN_KEY;
					state_nxt  = ST_RESULT;
				end else begin
					cmd.prod  = 1'b1;
					state_nxt = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_nxt = ST_LOCATE;
				end
			end
			ST_LOCATE: begin
				if (stat.loc_more) begin
					cmd.loc_step = 1'b1;
				end else if (stat.loc_past) begin
					status_nxt = STATUS_NO_PAIR;
					state_nxt  = ST_RESULT;
				end else begin
					state_nxt = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul   = 1'b1;
				state_nxt = ST_SUB;
			end
			ST_SUB: begin
				cmd.sub   = 1'b1;
				state_nxt = ST_SEARCH;
			end
			ST_SEARCH: begin
				if (stat.pair_hit) begin
					status_nxt = STATUS_FOUND;
					state_nxt  = ST_RESULT;
				end else if (stat.search_end) begin
					status_nxt = STATUS_NO_PAIR;
					state_nxt  = ST_RESULT;
				end else begin
					cmd.srch_step = 1'b1;
				end
			end
			ST_RESULT: begin
				if (stat.out_free) begin
					cmd.res_load = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

[design/dual_tone_common_period_search_top.sv]
// Channel  Direction  Handshake            Payload
// s        in         s_tvalid/s_tready    tdata: key_char, start_index
// m        out        m_tvalid/m_tready    tdata: status, low_tone_cycles, high_tone_cycles
// cfg      in         cfg_valid/cfg_ready  tolerance_inverse (always ready)
//
// One item at a time: key check, the threshold divider, a locate step per skipped
// diagonal, the two setup steps (multiply, subtract), then one candidate pair per
// cycle in the search loop, and finally loading the result.
// arst_n clears the controller, the output valid flag and the tolerance register.
// A stalled m side holds the result; the next item is taken meanwhile and its
// result waits in the controller until the output register frees.
`default_nettype none
module dual_tone_common_period_search_top (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 s_tvalid,
	output logic                                      s_tready,
	input  wire logic [dtcps_pkg::IN_DATA_WIDTH-1:0]  s_tdata,  // key_char, start_index, pad
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	output logic [dtcps_pkg::OUT_DATA_WIDTH-1:0]      m_tdata,  // status, low/high_tone_cycles
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [dtcps_pkg::TOL_WIDTH-1:0]      cfg_data
);
	import dtcps_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// sequencer
	dtcps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.cmd      (cmd),
		.stat     (stat)
	);

	// arithmetic, counters and output register
	dtcps_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule
`default_nettype wire
